// ===== src/srq_pkg.sv =====
// shared types, codes and limits for the sensor reading qualifier
// used by srq_cfg_regs, srq_qualify and sensor_reading_qualifier
package srq_pkg;

    // stream widths (payload packed from bit 0, padded to whole bytes)
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 152;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // accepted reading window and spike limits, hundredths
    localparam logic signed [15:0] TEMP_MIN      = -16'sd4000;
    localparam logic signed [15:0] TEMP_MAX      = 16'sd8500;
    localparam logic signed [15:0] HUM_MIN       = 16'sd0;
    localparam logic signed [15:0] HUM_MAX       = 16'sd10000;
    localparam logic signed [16:0] TEMP_STEP_MAX = 17'sd1000;
    localparam logic signed [16:0] HUM_STEP_MAX  = 17'sd2000;

    // register reset values
    localparam logic [7:0]  ERR_LIMIT_RST = 8'd3;
    localparam logic [15:0] INTERVAL_RST  = 16'd2000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_PRESENT = 3'd0,
        CFG_TEMP_OFFSET    = 3'd1,
        CFG_HUM_OFFSET     = 3'd2,
        CFG_ERROR_LIMIT    = 3'd3,
        CFG_READ_INTERVAL  = 3'd4
    } t_cfg_idx;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SKIPPED = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FAILED  = 3'd3,
        ST_RANGE   = 3'd4,
        ST_SPIKE   = 3'd5
    } t_status;

    typedef struct packed {
        logic               sensor_present;
        logic signed [11:0] temperature_offset;
        logic signed [11:0] humidity_offset;
        logic [7:0]         error_limit;
        logic [15:0]        read_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               sensor_answered;
        logic signed [15:0] raw_temperature;
        logic signed [15:0] raw_humidity;
    } t_item;

    typedef struct packed {
        logic               valid_flag;
        logic signed [14:0] temperature;
        logic signed [14:0] humidity;
        logic [15:0]        error_streak;
        logic [31:0]        good_total;
        logic [31:0]        bad_total;
        logic [31:0]        last_good_time;
    } t_state;

    typedef struct packed {
        logic    accepted;
        t_status status;
        logic    sensor_healthy;
    } t_verdict;

endpackage

// ===== src/srq_cfg_regs.sv =====
// configuration register bank for the sensor reading qualifier
// depends on srq_pkg
module srq_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [srq_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [srq_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output srq_pkg::t_cfg                    o_cfg
);

    srq_pkg::t_cfg r_cfg;
    srq_pkg::t_cfg n_cfg;

    // decode the write by register index, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (srq_pkg::t_cfg_idx'(i_wr_index))
                srq_pkg::CFG_SENSOR_PRESENT: n_cfg.sensor_present     = i_wr_data[0];
                srq_pkg::CFG_TEMP_OFFSET:    n_cfg.temperature_offset = i_wr_data[11:0];
                srq_pkg::CFG_HUM_OFFSET:     n_cfg.humidity_offset    = i_wr_data[11:0];
                srq_pkg::CFG_ERROR_LIMIT:    n_cfg.error_limit        = i_wr_data[7:0];
                srq_pkg::CFG_READ_INTERVAL:  n_cfg.read_interval_ms   = i_wr_data[15:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_present     <= 1'b0;
            r_cfg.temperature_offset <= '0;
            r_cfg.humidity_offset    <= '0;
            r_cfg.error_limit        <= srq_pkg::ERR_LIMIT_RST;
            r_cfg.read_interval_ms   <= srq_pkg::INTERVAL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/srq_qualify.sv =====
// combinational check of one read attempt against the kept state
// depends on srq_pkg; produces the next state and the verdict fields
module srq_qualify (
    input  srq_pkg::t_cfg     i_cfg,
    input  srq_pkg::t_item    i_item,
    input  srq_pkg::t_state   i_state,
    output srq_pkg::t_state   o_state,
    output srq_pkg::t_verdict o_verdict
);

    logic [31:0]        elapsed;
    logic               too_soon;
    logic               out_of_range;
    logic signed [16:0] diff_t;
    logic signed [16:0] diff_h;
    logic               spike;
    logic signed [16:0] sum_t;
    logic signed [16:0] sum_h;
    srq_pkg::t_state    nxt;

    // interval since the last good read, a zero time always lets the read through
    assign elapsed  = i_item.now_ms - i_state.last_good_time;
    assign too_soon = (i_state.last_good_time != 32'd0) && (elapsed[31:16] == 16'd0)
                      && (elapsed[15:0] < i_cfg.read_interval_ms);

    // physical range window
    assign out_of_range = (i_item.raw_temperature < srq_pkg::TEMP_MIN)
                       || (i_item.raw_temperature > srq_pkg::TEMP_MAX)
                       || (i_item.raw_humidity < srq_pkg::HUM_MIN)
                       || (i_item.raw_humidity > srq_pkg::HUM_MAX);

    // step against the stored calibrated values
    assign diff_t = {i_item.raw_temperature[15], i_item.raw_temperature}
                  - {{2{i_state.temperature[14]}}, i_state.temperature};
    assign diff_h = {i_item.raw_humidity[15], i_item.raw_humidity}
                  - {{2{i_state.humidity[14]}}, i_state.humidity};
    assign spike  = i_state.valid_flag
                 && ((diff_t > srq_pkg::TEMP_STEP_MAX) || (diff_t < -srq_pkg::TEMP_STEP_MAX)
                  || (diff_h > srq_pkg::HUM_STEP_MAX) || (diff_h < -srq_pkg::HUM_STEP_MAX));

    // calibrated values
    assign sum_t = {i_item.raw_temperature[15], i_item.raw_temperature}
                 + {{5{i_cfg.temperature_offset[11]}}, i_cfg.temperature_offset};
    assign sum_h = {i_item.raw_humidity[15], i_item.raw_humidity}
                 + {{5{i_cfg.humidity_offset[11]}}, i_cfg.humidity_offset};

    // checks in priority order
    always_comb begin
        nxt                = i_state;
        o_verdict.accepted = 1'b0;
        o_verdict.status   = srq_pkg::ST_OK;
        if (!i_cfg.sensor_present || (!too_soon && (!i_item.sensor_answered
                                      || out_of_range || spike))) begin
            // error path: bump counters, streak saturates
            if (i_state.error_streak != 16'hFFFF) begin
                nxt.error_streak = i_state.error_streak + 16'd1;
            end
            nxt.bad_total = i_state.bad_total + 32'd1;
        end
        if (!i_cfg.sensor_present) begin
            o_verdict.status = srq_pkg::ST_ABSENT;
        end else if (too_soon) begin
            o_verdict.status   = srq_pkg::ST_SKIPPED;
            o_verdict.accepted = i_state.valid_flag;
        end else if (!i_item.sensor_answered) begin
            o_verdict.status = srq_pkg::ST_FAILED;
            nxt.valid_flag   = 1'b0;
        end else if (out_of_range) begin
            o_verdict.status = srq_pkg::ST_RANGE;
            nxt.valid_flag   = 1'b0;
        end else if (spike) begin
            o_verdict.status = srq_pkg::ST_SPIKE;
            nxt.valid_flag   = 1'b0;
        end else begin
            nxt.temperature    = sum_t[14:0];
            nxt.humidity       = sum_h[14:0];
            nxt.valid_flag     = 1'b1;
            nxt.error_streak   = '0;
            nxt.good_total     = i_state.good_total + 32'd1;
            nxt.last_good_time = i_item.now_ms;
            o_verdict.accepted = 1'b1;
        end
    end

    // health follows the updated streak
    assign o_verdict.sensor_healthy = i_cfg.sensor_present
                                   && (nxt.error_streak < {8'd0, i_cfg.error_limit});
    assign o_state = nxt;

endmodule

// ===== src/sensor_reading_qualifier.sv =====
// top level of the sensor reading qualifier: input register, state and result register
// depends on srq_pkg, srq_cfg_regs and srq_qualify
//
// Qualifies one temperature/humidity read attempt per accepted input transfer and
// returns exactly one result transfer for each. Throughput is one item per clock
// while the output is not stalled: an item sits in the input register while the
// qualifier logic runs against the kept state, and the state and result register
// update together when the item moves on, so a following item already sees the effect
// of its predecessor. The result is registered: an item passes through the input
// register and then the result register. The result register decouples the
// output side: a new item is taken while a result waits, and input ready drops only
// when both registers are full and the output is stalled. Configuration writes are
// always ready and take effect at the next edge; write them only while the block is
// idle. Input tdata: now_ms[31:0], sensor_answered[32], raw_temperature[48:33],
// raw_humidity[64:49]. Output tdata: accepted[0], status[3:1], temperature[18:4],
// humidity[33:19], value_valid[34], error_run[50:35], sensor_healthy[51],
// good_count[83:52], bad_count[115:84], last_good_ms[147:116].
module sensor_reading_qualifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms, sensor_answered, raw_temperature, raw_humidity, zero pad
    input  logic [srq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // accepted, status, temperature, humidity, value_valid, error_run,
    // sensor_healthy, good_count, bad_count, last_good_ms, zero pad
    output logic [srq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [srq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    srq_pkg::t_cfg     cfg;
    srq_pkg::t_item    in_item;
    srq_pkg::t_state   n_state;
    srq_pkg::t_verdict verdict;
    logic              advance;
    logic              in_xfer;

    logic              r_in_valid;
    srq_pkg::t_item    r_in_item;
    srq_pkg::t_state   r_state;
    logic              r_out_valid;
    logic [srq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [srq_pkg::OUT_DATA_W-1:0] n_out_data;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    srq_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake: the held item moves on when the result register frees up
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // unpack the input transfer
    assign in_item.now_ms          = s_axis_tdata[31:0];
    assign in_item.sensor_answered = s_axis_tdata[32];
    assign in_item.raw_temperature = s_axis_tdata[48:33];
    assign in_item.raw_humidity    = s_axis_tdata[64:49];

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= in_item;
        end
    end

    // qualifier logic
    srq_qualify u_qualify (
        .i_cfg     (cfg),
        .i_item    (r_in_item),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_verdict (verdict)
    );

    // kept state updates only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result packing
    always_comb begin
        n_out_data           = '0;
        n_out_data[0]        = verdict.accepted;
        n_out_data[3:1]      = verdict.status;
        n_out_data[18:4]     = n_state.temperature;
        n_out_data[33:19]    = n_state.humidity;
        n_out_data[34]       = n_state.valid_flag;
        n_out_data[50:35]    = n_state.error_streak;
        n_out_data[51]       = verdict.sensor_healthy;
        n_out_data[83:52]    = n_state.good_total;
        n_out_data[115:84]   = n_state.bad_total;
        n_out_data[147:116]  = n_state.last_good_time;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
